### rtl/ufm_pkg.sv
// Package for the unrestricted Fock matrix builder: sizes, command codes and fixed point helpers.
// No dependencies.
package ufm_pkg;
    localparam int MaxBasis  = 8;
    localparam int IdxW      = 3;
    localparam int ValueW    = 32;
    localparam int AccW      = 64;
    localparam int FracBits  = 16;
    localparam int Nb2       = MaxBasis * MaxBasis;
    localparam int Nb4       = Nb2 * Nb2;
    localparam int A2W       = 2 * IdxW;
    localparam int A4W       = 4 * IdxW;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_CORE     = 3'd0;
    localparam t_cmd CMD_INTEGRAL = 3'd1;
    localparam t_cmd CMD_DEN_UP   = 3'd2;
    localparam t_cmd CMD_DEN_DOWN = 3'd3;
    localparam t_cmd CMD_COMPUTE  = 3'd4;

    typedef struct packed {
        t_cmd                     command;
        logic [IdxW-1:0]          index_p;
        logic [IdxW-1:0]          index_q;
        logic [IdxW-1:0]          index_r;
        logic [IdxW-1:0]          index_s;
        logic signed [ValueW-1:0] value;
    } t_in;

    typedef struct packed {
        logic [IdxW-1:0]          row;
        logic [IdxW-1:0]          col;
        logic signed [ValueW-1:0] fock_up;
        logic signed [ValueW-1:0] fock_down;
        logic                     saturated;
        logic                     last;
    } t_out;

    // Memory read request from the sequencer.
    typedef struct packed {
        logic [IdxW-1:0] p;
        logic [IdxW-1:0] q;
        logic [IdxW-1:0] r;
        logic [IdxW-1:0] s;
    } t_rd;

    function automatic logic signed [AccW-1:0] sat_val(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = AccW'((64'sd1 <<< (ValueW - 1)) - 64'sd1);
        lo = -hi - AccW'(1);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction
endpackage

### rtl/ufm_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies.
interface ufm_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ufm_cfg_if.sv
// Configuration write channel: valid, ready and the basis count.
// No dependencies.
interface ufm_cfg_if ();
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/uhf_fock_matrix_build_top.sv
// Top level of the unrestricted Fock matrix builder: sequencer, Fock result memory and output
// register. Depends on ufm_pkg, ufm_if, ufm_cfg_if, ufm_store and ufm_mac.
// Load commands are written to the operand memories while idle. A compute command builds
// the upper triangle with one (r,s) term per cycle through the multiply-accumulate unit,
// then emits N*N entries row by row, one per cycle from the Fock memory while the output
// is taken. Input is held off during compute.
module uhf_fock_matrix_build_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ufm_if.sink     in_ch,
    ufm_if.source   out_ch,
    ufm_cfg_if.sink cfg_ch
);
    import ufm_pkg::*;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_WRB  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]      r_state;
    logic [IdxW:0]   r_n;
    logic [3:0]      r_cfg;
    logic [IdxW-1:0] r_p, r_q, r_r, r_s;
    logic [1:0]      r_wait;
    logic            r_start, r_start_d, r_mvalid;
    logic [64:0]     fock_mem [Nb2];
    logic [64:0]     r_rdata;
    logic            r_rv, r_rlast;
    logic [IdxW-1:0] r_rrow, r_rcol;
    t_out            r_out;
    logic            r_ov;
    t_rd             rd;
    logic signed [ValueW-1:0] core, qa, qb, pu, pd;
    logic signed [AccW-1:0]   up, dn, su, sd;
    logic            mac_v, fire_ld, lastr, lasts, adv;
    logic [IdxW-1:0] nm1;

    assign nm1 = IdxW'(r_n - 1'b1);
    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (r_state == ST_IDLE);
    assign fire_ld = in_ch.valid && in_ch.ready && in_ch.data.command != CMD_COMPUTE;
    assign rd = '{p: r_p, q: r_q, r: r_r, s: r_s};
    assign mac_v = (r_state == ST_MAC);
    assign lastr = (r_r == nm1);
    assign lasts = (r_s == nm1);

    ufm_store u_store (
        .i_clk(i_clk), .i_we(fire_ld), .i_wr(in_ch.data), .i_rd(rd),
        .o_core(core), .o_qa(qa), .o_qb(qb), .o_pu(pu), .o_pd(pd)
    );

    ufm_mac u_mac (
        .i_clk(i_clk), .i_start(r_start_d), .i_valid(r_mvalid),
        .i_core(core), .i_qa(qa), .i_qb(qb), .i_pu(pu), .i_pd(pd),
        .o_up(up), .o_dn(dn)
    );

    assign su = sat_val(up);
    assign sd = sat_val(dn);
    assign adv = !r_ov || out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= 4'd8;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
            r_start <= 1'b0;
            r_start_d <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            if (cfg_ch.valid) r_cfg <= cfg_ch.data;
            r_start_d <= r_start;
            r_mvalid  <= mac_v;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_ch.valid && in_ch.data.command == CMD_COMPUTE) begin
                        r_n <= (r_cfg == 4'd0) ? (IdxW+1)'(1) :
                               (r_cfg > 4'(MaxBasis)) ? (IdxW+1)'(MaxBasis)
                                                      : (IdxW+1)'(r_cfg);
                        r_p <= '0; r_q <= '0; r_r <= '0; r_s <= '0;
                        r_start <= 1'b1;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_start <= 1'b0;
                    if (lasts) begin
                        r_s <= '0;
                        if (lastr) begin
                            r_wait  <= '0;
                            r_state <= ST_WAIT;
                        end else r_r <= r_r + 1'b1;
                    end else r_s <= r_s + 1'b1;
                end
                ST_WAIT: begin
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == 2'd2) r_state <= ST_WRB;
                end
                ST_WRB: begin
                    fock_mem[{r_p, r_q}] <= {(su != up) || (sd != dn),
                                             sd[ValueW-1:0], su[ValueW-1:0]};
                    r_r <= '0;
                    if (r_q == nm1) begin
                        if (r_p == nm1) begin
                            r_p <= '0; r_q <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_p <= r_p + 1'b1;
                            r_q <= r_p + 1'b1;
                            r_start <= 1'b1;
                            r_state <= ST_MAC;
                        end
                    end else begin
                        r_q <= r_q + 1'b1;
                        r_start <= 1'b1;
                        r_state <= ST_MAC;
                    end
                end
                ST_EMIT: begin
                    if (!r_rv || adv) begin
                        r_rv    <= 1'b1;
                        r_rrow  <= r_p;
                        r_rcol  <= r_q;
                        r_rlast <= (r_p == nm1) && (r_q == nm1);
                        r_rdata <= fock_mem[(r_p <= r_q) ? {r_p, r_q} : {r_q, r_p}];
                        if (r_q == nm1) begin
                            r_q <= '0;
                            if (r_p == nm1) r_state <= ST_IDLE;
                            else r_p <= r_p + 1'b1;
                        end else r_q <= r_q + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_rv && adv) begin
                r_ov  <= 1'b1;
                r_out <= '{row: r_rrow, col: r_rcol,
                           fock_up: r_rdata[ValueW-1:0],
                           fock_down: r_rdata[2*ValueW-1:ValueW],
                           saturated: r_rdata[2*ValueW], last: r_rlast};
                if (!(r_state == ST_EMIT)) r_rv <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;
endmodule

### rtl/ufm_mac.sv
// Multiply-accumulate datapath: four floor-shifted Q16.16 products per step.
// Depends on ufm_pkg.
module ufm_mac (
    input  logic                              i_clk,
    input  logic                              i_start,
    input  logic                              i_valid,
    input  logic signed [ufm_pkg::ValueW-1:0] i_core,
    input  logic signed [ufm_pkg::ValueW-1:0] i_qa,
    input  logic signed [ufm_pkg::ValueW-1:0] i_qb,
    input  logic signed [ufm_pkg::ValueW-1:0] i_pu,
    input  logic signed [ufm_pkg::ValueW-1:0] i_pd,
    output logic signed [ufm_pkg::AccW-1:0]   o_up,
    output logic signed [ufm_pkg::AccW-1:0]   o_dn
);
    import ufm_pkg::*;
    logic signed [AccW-1:0] r_puqa, r_pdqa, r_puqb, r_pdqb, r_up, r_dn;
    logic                   r_pv;

    always_ff @(posedge i_clk) begin
        r_pv   <= i_valid;
        r_puqa <= (AccW'(i_pu) * AccW'(i_qa)) >>> FracBits;
        r_pdqa <= (AccW'(i_pd) * AccW'(i_qa)) >>> FracBits;
        r_puqb <= (AccW'(i_pu) * AccW'(i_qb)) >>> FracBits;
        r_pdqb <= (AccW'(i_pd) * AccW'(i_qb)) >>> FracBits;
        if (i_start) begin
            r_up <= AccW'(i_core);
            r_dn <= AccW'(i_core);
        end else if (r_pv) begin
            r_up <= r_up + r_puqa - r_puqb + r_pdqa;
            r_dn <= r_dn + r_pdqa - r_pdqb + r_puqa;
        end
    end
    assign o_up = r_up;
    assign o_dn = r_dn;
endmodule

### rtl/ufm_store.sv
// Operand memories: core, integrals (two read ports), densities, registered reads.
// Depends on ufm_pkg.
module ufm_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  ufm_pkg::t_in                      i_wr,
    input  ufm_pkg::t_rd                      i_rd,
    output logic signed [ufm_pkg::ValueW-1:0] o_core,
    output logic signed [ufm_pkg::ValueW-1:0] o_qa,
    output logic signed [ufm_pkg::ValueW-1:0] o_qb,
    output logic signed [ufm_pkg::ValueW-1:0] o_pu,
    output logic signed [ufm_pkg::ValueW-1:0] o_pd
);
    import ufm_pkg::*;
    logic [ValueW-1:0] core_mem [Nb2];
    logic [ValueW-1:0] intg_mem [Nb4];
    logic [ValueW-1:0] dup_mem  [Nb2];
    logic [ValueW-1:0] ddn_mem  [Nb2];
    logic [A2W-1:0]    wa2;
    logic [A4W-1:0]    wa4;

    assign wa2 = {i_wr.index_p, i_wr.index_q};
    assign wa4 = {i_wr.index_p, i_wr.index_q, i_wr.index_r, i_wr.index_s};

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            unique case (i_wr.command)
                CMD_CORE:     core_mem[wa2] <= i_wr.value;
                CMD_INTEGRAL: intg_mem[wa4] <= i_wr.value;
                CMD_DEN_UP:   dup_mem[wa2]  <= i_wr.value;
                CMD_DEN_DOWN: ddn_mem[wa2]  <= i_wr.value;
                default: ;
            endcase
        end
        o_core <= core_mem[{i_rd.p, i_rd.q}];
        o_qa   <= intg_mem[{i_rd.p, i_rd.q, i_rd.r, i_rd.s}];
        o_qb   <= intg_mem[{i_rd.p, i_rd.s, i_rd.r, i_rd.q}];
        o_pu   <= dup_mem[{i_rd.s, i_rd.r}];
        o_pd   <= ddn_mem[{i_rd.s, i_rd.r}];
    end
endmodule

### rtl/ufm_checker.sv
// Port-level checker for the unrestricted Fock matrix builder, bound to the top level.
// Depends on ufm_pkg.
module ufm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input ufm_pkg::t_out out_data
);
    import ufm_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("handshake signal unknown");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.last |-> out_data.row == out_data.col)
        else $error("last beat off the diagonal");
endmodule

bind uhf_fock_matrix_build_top ufm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

### tb/ufm_fock_checker.sv
// Checker for the unrestricted Fock matrix builder: mirrors the loaded tables and the basis
// count, predicts every emitted Fock entry and compares the output beats in order.
// Depends on ufm_pkg.
module ufm_fock_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  ufm_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  ufm_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [3:0]    i_cfg_data,
    output int            o_fail_count,
    output int            o_entries_pending
);
    import ufm_pkg::*;
    logic signed [ValueW-1:0] core_h [Nb2];
    logic signed [ValueW-1:0] eri    [Nb4];
    logic signed [ValueW-1:0] dens_up[Nb2];
    logic signed [ValueW-1:0] dens_dn[Nb2];
    logic [3:0]               basis_reg;
    t_out                     fock_entries_due[$];
    int                       fails;

    assign o_fail_count      = fails;
    assign o_entries_pending = fock_entries_due.size();

    function automatic longint fixed_mul(logic signed [ValueW-1:0] a,
                                         logic signed [ValueW-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FracBits;
    endfunction

    function automatic logic signed [ValueW-1:0] clip_word(longint x, inout logic clipped);
        if (x > longint'(32'sh7fffffff)) begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < longint'(32'sh80000000)) begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return x[ValueW-1:0];
    endfunction

    task automatic predict_fock(int n);
        logic signed [ValueW-1:0] fu [Nb2];
        logic signed [ValueW-1:0] fd [Nb2];
        logic                     sat[Nb2];
        longint                   acc_up, acc_dn, pu_qa, pd_qa;
        logic signed [ValueW-1:0] qa, qb, pu, pd;
        logic                     clipped;
        t_out                     e;
        for (int p = 0; p < n; p++) begin
            for (int q = p; q < n; q++) begin
                acc_up = longint'(core_h[p*MaxBasis+q]);
                acc_dn = acc_up;
                clipped = 1'b0;
                for (int r = 0; r < n; r++) begin
                    for (int s = 0; s < n; s++) begin
                        qa = eri[((p*MaxBasis+q)*MaxBasis+r)*MaxBasis+s];
                        qb = eri[((p*MaxBasis+s)*MaxBasis+r)*MaxBasis+q];
                        pu = dens_up[s*MaxBasis+r];
                        pd = dens_dn[s*MaxBasis+r];
                        pu_qa = fixed_mul(pu, qa);
                        pd_qa = fixed_mul(pd, qa);
                        acc_up += pu_qa - fixed_mul(pu, qb) + pd_qa;
                        acc_dn += pd_qa - fixed_mul(pd, qb) + pu_qa;
                    end
                end
                fu[p*MaxBasis+q] = clip_word(acc_up, clipped);
                fd[p*MaxBasis+q] = clip_word(acc_dn, clipped);
                sat[p*MaxBasis+q] = clipped;
                fu[q*MaxBasis+p] = fu[p*MaxBasis+q];
                fd[q*MaxBasis+p] = fd[p*MaxBasis+q];
                sat[q*MaxBasis+p] = clipped;
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                e.row       = i[IdxW-1:0];
                e.col       = j[IdxW-1:0];
                e.fock_up   = fu[i*MaxBasis+j];
                e.fock_down = fd[i*MaxBasis+j];
                e.saturated = sat[i*MaxBasis+j];
                e.last      = (i == n - 1) && (j == n - 1);
                fock_entries_due = {fock_entries_due, e};
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            basis_reg = 4'd8;
            fails     = 0;
            fock_entries_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                basis_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.command)
                    CMD_CORE: begin
                        core_h[{i_in_data.index_p, i_in_data.index_q}] = i_in_data.value;
                    end
                    CMD_INTEGRAL: begin
                        eri[{i_in_data.index_p, i_in_data.index_q,
                             i_in_data.index_r, i_in_data.index_s}] = i_in_data.value;
                    end
                    CMD_DEN_UP: begin
                        dens_up[{i_in_data.index_p, i_in_data.index_q}] = i_in_data.value;
                    end
                    CMD_DEN_DOWN: begin
                        dens_dn[{i_in_data.index_p, i_in_data.index_q}] = i_in_data.value;
                    end
                    CMD_COMPUTE: begin
                        predict_fock(basis_reg == 0 ? 1 :
                                     (basis_reg > MaxBasis ? MaxBasis : int'(basis_reg)));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (fock_entries_due.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected beat, expected no beat, actual row %0d col %0d ",
                              "up %0d dn %0d"},
                             $time, i_out_data.row, i_out_data.col,
                             i_out_data.fock_up, i_out_data.fock_down);
                end else begin
                    if (i_out_data !== fock_entries_due[0]) begin
                        fails++;
                        $display({"%0t: mismatch, expected row %0d col %0d up %0d dn %0d ",
                                  "sat %0b last %0b, actual row %0d col %0d up %0d dn %0d ",
                                  "sat %0b last %0b"}, $time,
                                 fock_entries_due[0].row, fock_entries_due[0].col,
                                 fock_entries_due[0].fock_up, fock_entries_due[0].fock_down,
                                 fock_entries_due[0].saturated, fock_entries_due[0].last,
                                 i_out_data.row, i_out_data.col, i_out_data.fock_up,
                                 i_out_data.fock_down, i_out_data.saturated, i_out_data.last);
                    end
                    void'(fock_entries_due.pop_front());
                end
            end
        end
    end
endmodule

### tb/uhf_fock_matrix_build_top_test.sv
// Stimulus top for the unrestricted Fock matrix builder: loads tables, issues computes under
// several idling patterns and basis counts, and reports the verdict.
// Depends on ufm_pkg, ufm_if, ufm_cfg_if, ufm_fock_checker and the block's top level.
module uhf_fock_matrix_build_top_test;
    import ufm_pkg::*;

    localparam int CycleLimit = 100000;
    localparam int DrainWait  = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   fail_count;
    int   entries_pending;

    bit core_set[Nb2];
    bit up_set[Nb2];
    bit dn_set[Nb2];
    bit eri_set[Nb4];

    ufm_if #(.t_payload(t_in))  in_if ();
    ufm_if #(.t_payload(t_out)) out_if ();
    ufm_cfg_if                  cfg_if ();

    uhf_fock_matrix_build_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if.sink),
        .out_ch  (out_if.source),
        .cfg_ch  (cfg_if.sink)
    );

    ufm_fock_checker checker_u (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_if.valid),
        .i_in_ready        (in_if.ready),
        .i_in_data         (in_if.data),
        .i_out_valid       (out_if.valid),
        .i_out_ready       (out_if.ready),
        .i_out_data        (out_if.data),
        .i_cfg_valid       (cfg_if.valid),
        .i_cfg_ready       (cfg_if.ready),
        .i_cfg_data        (cfg_if.data),
        .o_fail_count      (fail_count),
        .o_entries_pending (entries_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [ValueW-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed(ValueW'($urandom_range(262143))) - 32'sd131072;
        endcase
    endfunction

    task automatic send_beat(t_cmd cmd, int p, int q, int r, int s,
                             logic signed [ValueW-1:0] v);
        t_in b;
        b.command = cmd;
        b.index_p = p[IdxW-1:0];
        b.index_q = q[IdxW-1:0];
        b.index_r = r[IdxW-1:0];
        b.index_s = s[IdxW-1:0];
        b.value   = v;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (!in_if.ready);
        if (cmd == CMD_CORE) core_set[p*MaxBasis+q] = 1'b1;
        if (cmd == CMD_DEN_UP) up_set[p*MaxBasis+q] = 1'b1;
        if (cmd == CMD_DEN_DOWN) dn_set[p*MaxBasis+q] = 1'b1;
        if (cmd == CMD_INTEGRAL) eri_set[((p*MaxBasis+q)*MaxBasis+r)*MaxBasis+s] = 1'b1;
    endtask

    task automatic fill_missing(int n);
        for (int p = 0; p < n; p++) begin
            for (int q = 0; q < n; q++) begin
                if (!core_set[p*MaxBasis+q]) send_beat(CMD_CORE, p, q, 0, 0, pick_value());
                if (!up_set[p*MaxBasis+q]) send_beat(CMD_DEN_UP, p, q, 0, 0, pick_value());
                if (!dn_set[p*MaxBasis+q]) send_beat(CMD_DEN_DOWN, p, q, 0, 0, pick_value());
                for (int r = 0; r < n; r++) begin
                    for (int s = 0; s < n; s++) begin
                        if (!eri_set[((p*MaxBasis+q)*MaxBasis+r)*MaxBasis+s]) begin
                            send_beat(CMD_INTEGRAL, p, q, r, s, pick_value());
                        end
                    end
                end
            end
        end
    endtask

    task automatic settle_and_configure(logic [3:0] count);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (entries_pending == 0);
        repeat (DrainWait) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= count;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_burst(int n, int beats);
        int lim;
        for (int k = 0; k < beats; k++) begin
            lim = ($urandom_range(4) == 0) ? MaxBasis - 1 : n - 1;
            case ($urandom_range(9))
                0: send_beat(t_cmd'($urandom_range(7, 5)), $urandom_range(7),
                             $urandom_range(7), $urandom_range(7), $urandom_range(7), $urandom);
                1: send_beat(CMD_CORE, $urandom_range(lim), $urandom_range(lim),
                             $urandom_range(7), $urandom_range(7), pick_value());
                2: send_beat(CMD_DEN_UP, $urandom_range(lim), $urandom_range(lim),
                             $urandom_range(7), $urandom_range(7), pick_value());
                3: send_beat(CMD_DEN_DOWN, $urandom_range(lim), $urandom_range(lim),
                             $urandom_range(7), $urandom_range(7), pick_value());
                default: send_beat(CMD_INTEGRAL, $urandom_range(lim), $urandom_range(lim),
                                   $urandom_range(lim), $urandom_range(lim), pick_value());
            endcase
        end
        fill_missing(n);
        send_beat(CMD_COMPUTE, $urandom_range(7), $urandom_range(7),
                  $urandom_range(7), $urandom_range(7), $urandom);
    endtask

    initial begin
        logic [3:0] counts[3];
        int         modes[4][2];
        int         n;
        counts = '{4'd3, 4'd0, 4'd2};
        modes  = '{'{0, 0}, '{73, 0}, '{0, 73}, '{13, 13}};
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        settle_and_configure(4'd1);
        send_beat(CMD_CORE, 0, 0, 0, 0, 32'sh7fffffff);
        send_beat(CMD_INTEGRAL, 0, 0, 0, 0, 32'sh7fffffff);
        send_beat(CMD_DEN_UP, 0, 0, 0, 0, 32'sh7fffffff);
        send_beat(CMD_DEN_DOWN, 0, 0, 0, 0, 32'sh80000000);
        send_beat(CMD_COMPUTE, 0, 0, 0, 0, 0);
        send_beat(CMD_CORE, 0, 0, 0, 0, 32'sh80000000);
        send_beat(CMD_DEN_DOWN, 0, 0, 0, 0, 32'sh7fffffff);
        send_beat(CMD_COMPUTE, 7, 7, 7, 7, 32'sh7fffffff);
        send_beat(t_cmd'(5), 0, 0, 0, 0, 32'sh12345678);
        send_beat(t_cmd'(6), 7, 7, 7, 7, 32'sh80000000);
        send_beat(t_cmd'(7), 3, 4, 5, 6, 32'sh7fffffff);
        send_beat(CMD_CORE, 7, 7, 7, 7, 32'sh00010000);
        send_beat(CMD_INTEGRAL, 7, 7, 7, 7, 32'sh00010000);
        send_beat(CMD_DEN_UP, 0, 0, 0, 0, 32'sh00000000);
        send_beat(CMD_DEN_DOWN, 0, 0, 0, 0, 32'shffffffff);
        send_beat(CMD_COMPUTE, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 3; ph++) begin
            settle_and_configure(counts[ph]);
            n = (counts[ph] == 0) ? 1 : ((counts[ph] > MaxBasis) ? MaxBasis : counts[ph]);
            for (int m = 0; m < 4; m++) begin
                send_idle_pct  = modes[(ph + m) % 4][0];
                recv_stall_pct = modes[(ph + m) % 4][1];
                random_burst(n, 1);
            end
        end
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (entries_pending == 0);
        repeat (DrainWait) @(posedge i_clk);
        if (fail_count == 0 && entries_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
